// File: src/activity_log_record_parser_defines.svh
// ---------------------------------------------------------------------------
// activity log record parser assertion macros
// concurrent assertion helpers shared by the parser rtl
// ---------------------------------------------------------------------------
`ifndef ACTIVITY_LOG_RECORD_PARSER_DEFINES_SVH
`define ACTIVITY_LOG_RECORD_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define ALRP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ALRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ALRP_ASSERT(label, clk, rst, prop, msg)

`define ALRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/alrp_pkg.sv
// ---------------------------------------------------------------------------
// activity log record parser package
// field widths, bias constants and parser state type
// ---------------------------------------------------------------------------
`default_nettype none

package alrp_pkg;

   localparam int BYTE_W     = 8;
   localparam int TIME_W     = 32;
   localparam int KIND_W     = 8;
   localparam int ACT_W      = 9;
   localparam int STEP_W     = 8;
   localparam int RSP_DATA_W = 64;

   localparam int LEAD_TOP_BIT = 7;

   localparam logic [KIND_W-1:0] KIND_BIAS      = 8'h81;
   localparam logic [ACT_W-1:0]  ACTIVITY_BIAS  = 9'd10;
   localparam logic [TIME_W-1:0] MINUTE_SECONDS = 32'd60;

   typedef enum logic [2:0] {
      ST_LEAD,
      ST_TIME1,
      ST_TIME2,
      ST_TIME3,
      ST_ACTIVITY,
      ST_STEPS
   } parse_state_type;

endpackage

`default_nettype wire

// File: src/activity_log_record_parser.sv
// ---------------------------------------------------------------------------
// activity log record parser
// a steps byte is held in the input register, then loads the result register behind rsp_tvalid
// throughput: one byte per cycle while the input is not stalled
// a result stalls the input only while the output register is full
// reset: clears parse state, current time and emit filter time to zero
// ---------------------------------------------------------------------------
`default_nettype none

`include "activity_log_record_parser_defines.svh"

module activity_log_record_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [alrp_pkg::BYTE_W-1:0]    req_tdata,  // data_byte
   input  wire logic                           req_tlast,  // last_byte
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // record_time[31:0], record_kind[39:32], activity_tenths[48:40],
   // step_count[56:49], zero pad[63:57]
   output logic [alrp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                           csr_we,
   input  wire logic [alrp_pkg::TIME_W-1:0]    csr_wdata
);

   import alrp_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // parse state
   parse_state_type   state_ff, state_in;
   logic [TIME_W-1:0] assembly_ff, assembly_in;
   logic [TIME_W-1:0] cur_time_ff, cur_time_in;
   logic [BYTE_W-1:0] marker_ff, marker_in;
   logic [BYTE_W-1:0] activity_ff, activity_in;
   logic [TIME_W-1:0] last_emit_ff, last_emit_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] out_time_ff;
   logic [KIND_W-1:0] out_kind_ff;
   logic [ACT_W-1:0]  out_act_ff;
   logic [STEP_W-1:0] out_step_ff;

   logic consume;
   logic emit;
   logic req_xfer;

   assign consume    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;
   assign req_xfer   = req_tvalid && req_tready;
   assign emit       = consume && (state_ff == ST_STEPS) && (cur_time_ff > last_emit_ff);

   assign in_valid_in = req_xfer ? 1'b1 : (consume ? 1'b0 : in_valid_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      if (consume) begin
         unique case (state_ff)
            ST_LEAD:     state_in = in_byte_ff[LEAD_TOP_BIT] ? ST_ACTIVITY : ST_TIME1;
            ST_TIME1:    state_in = ST_TIME2;
            ST_TIME2:    state_in = ST_TIME3;
            ST_TIME3:    state_in = ST_LEAD;
            ST_ACTIVITY: state_in = ST_STEPS;
            ST_STEPS:    state_in = ST_LEAD;
            default:     state_in = ST_LEAD;
         endcase
         if (in_last_ff) begin
            state_in = ST_LEAD;
         end
      end
   end

   // datapath updates
   always_comb begin
      assembly_in  = assembly_ff;
      cur_time_in  = cur_time_ff;
      marker_in    = marker_ff;
      activity_in  = activity_ff;
      last_emit_in = last_emit_ff;
      if (consume) begin
         unique case (state_ff)
            ST_LEAD: begin
               if (in_byte_ff[LEAD_TOP_BIT]) begin
                  marker_in = in_byte_ff;
               end else begin
                  assembly_in = {{(TIME_W-BYTE_W){1'b0}}, in_byte_ff};
               end
            end
            ST_TIME1, ST_TIME2: begin
               assembly_in = {assembly_ff[TIME_W-BYTE_W-1:0], in_byte_ff};
            end
            ST_TIME3: begin
               assembly_in = {assembly_ff[TIME_W-BYTE_W-1:0], in_byte_ff};
               cur_time_in = {assembly_ff[TIME_W-BYTE_W-1:0], in_byte_ff};
            end
            ST_ACTIVITY: begin
               activity_in = in_byte_ff;
            end
            ST_STEPS: begin
               cur_time_in = cur_time_ff + MINUTE_SECONDS;
               if (emit) begin
                  last_emit_in = cur_time_ff;
               end
            end
            default: begin
               assembly_in = assembly_ff;
            end
         endcase
         if (in_last_ff) begin
            assembly_in = '0;
            cur_time_in = '0;
         end
      end
      if (csr_we) begin
         last_emit_in = csr_wdata;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= ST_LEAD;
         assembly_ff  <= '0;
         cur_time_ff  <= '0;
         marker_ff    <= '0;
         activity_ff  <= '0;
         last_emit_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         assembly_ff  <= assembly_in;
         cur_time_ff  <= cur_time_in;
         marker_ff    <= marker_in;
         activity_ff  <= activity_in;
         last_emit_ff <= last_emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (emit) begin
         out_time_ff <= cur_time_ff;
         out_kind_ff <= marker_ff - KIND_BIAS;
         out_act_ff  <= {1'b0, activity_ff} - ACTIVITY_BIAS;
         out_step_ff <= in_byte_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TIME_W-KIND_W-ACT_W-STEP_W){1'b0}},
                        out_step_ff, out_act_ff, out_kind_ff, out_time_ff};

   `ALRP_ASSERT_NEXT(a_emit_loads_result, clock, reset, emit, rsp_valid_ff && (out_time_ff == $past(cur_time_ff)), "result register not loaded on emit")
   `ALRP_ASSERT_NEXT(a_emit_moves_filter, clock, reset, emit && !csr_we, last_emit_ff == out_time_ff, "filter time not updated on emit")
   `ALRP_ASSERT_NEXT(a_last_clears_parse, clock, reset, consume && in_last_ff, (state_ff == ST_LEAD) && (cur_time_ff == '0), "parse state not cleared after last byte")
   `ALRP_ASSERT(a_empty_input_ready, clock, reset, !in_valid_ff |-> req_tready, "input register empty but not ready")

endmodule

`default_nettype wire
